FILE: sv/gated_pose_accumulator_core_defines.svh
// Assertion helpers for the pose accumulator checker.
// Both sample on clk and stay quiet while rst is high.
`ifndef GATED_POSE_ACCUMULATOR_CORE_DEFINES_SVH
`define GATED_POSE_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define GPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gpa_pkg.sv
`default_nettype none

package gpa_pkg;

  localparam int DATA_W = 32;
  localparam int ROWS   = 3;
  localparam int COLS   = 4;
  localparam int TERMS  = 3;

  localparam logic [1:0] ROW_LAST = 2'd2;

  // gate_mode codes
  localparam logic [1:0] GATE_FINE   = 2'd0;
  localparam logic [1:0] GATE_COARSE = 2'd1;
  localparam logic [1:0] GATE_HOLD   = 2'd2;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } gpa_lane_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/gated_pose_accumulator_core.sv
// Row 0 of an item's result is valid once the item has passed S_MUL0,
// S_MUL1, S_MUL2 and S_DONE; rows 1 and 2 follow on the next cycles when
// out_stall is low. A new item is taken only as the last one finishes, set by the
// three-term multiply-accumulate of twelve lanes, feeding the next item's pose if the gate passes.
// Reset: the pose returns to identity, gate_mode to 0, no result is pending.
`default_nettype none

module gated_pose_accumulator_core import gpa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] r00,
  input  logic signed [DATA_W-1:0] r01,
  input  logic signed [DATA_W-1:0] r02,
  input  logic signed [DATA_W-1:0] r10,
  input  logic signed [DATA_W-1:0] r11,
  input  logic signed [DATA_W-1:0] r12,
  input  logic signed [DATA_W-1:0] r20,
  input  logic signed [DATA_W-1:0] r21,
  input  logic signed [DATA_W-1:0] r22,
  input  logic signed [DATA_W-1:0] tx,
  input  logic signed [DATA_W-1:0] ty,
  input  logic signed [DATA_W-1:0] tz,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               row_index,
  output logic signed [DATA_W-1:0] col0,
  output logic signed [DATA_W-1:0] col1,
  output logic signed [DATA_W-1:0] col2,
  output logic signed [DATA_W-1:0] col3,
  output logic                     accepted,
  output logic                     last_row
);

  typedef enum logic [1:0] {S_MUL0, S_MUL1, S_MUL2, S_DONE} step_t;

  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) <<< FRAC_BITS;

  step_t                     step;
  logic                      busy;
  logic [1:0]                gate_mode;
  logic [1:0]                out_row;
  logic                      out_ok;
  logic signed [DATA_W-1:0]  pose     [ROWS][COLS];
  logic signed [DATA_W-1:0]  lane_res [ROWS][COLS];
  logic signed [DATA_W-1:0]  rot_q    [TERMS][TERMS];
  logic signed [DATA_W-1:0]  t_q      [TERMS];
  logic [1:0]                k;
  logic                      gate_ok;
  logic                      in_acc;
  logic                      out_free;
  logic                      finish;
  gpa_lane_ctrl_t            lane_ctrl;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || ((out_row == ROW_LAST) && !out_stall);
  assign finish   = busy && (step == S_DONE) && out_free;
  assign in_stall = busy && !finish;

  always_comb begin
    unique case (step)
      S_MUL0:  k = 2'd0;
      S_MUL1:  k = 2'd1;
      S_MUL2:  k = 2'd2;
      S_DONE:  k = 2'd0;
    endcase
  end

  assign lane_ctrl.mul_en   = busy && (step != S_DONE);
  assign lane_ctrl.acc_load = busy && (step == S_MUL1);
  assign lane_ctrl.acc_add  = busy && (step == S_MUL2);

  gpa_gate #(.FRAC_BITS(FRAC_BITS)) u_gate (
    .clk  (clk),
    .mode (gate_mode),
    .tx   (t_q[0]),
    .ty   (t_q[1]),
    .tz   (t_q[2]),
    .ok   (gate_ok)
  );

  for (genvar i = 0; i < ROWS; i++) begin : g_row
    for (genvar j = 0; j < COLS; j++) begin : g_col
      logic signed [DATA_W-1:0] op_b;
      logic signed [DATA_W-1:0] offset;
      if (j == COLS - 1) begin : g_trans
        assign op_b   = t_q[k];
        assign offset = pose[i][COLS-1];
      end else begin : g_rot
        assign op_b   = rot_q[k][j];
        assign offset = '0;
      end
      gpa_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .op_a   (pose[i][k]),
        .op_b   (op_b),
        .offset (offset),
        .result (lane_res[i][j])
      );
    end
  end

  // Hold the request while the lanes work on it.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rot_q[0][0] <= r00;
      rot_q[0][1] <= r01;
      rot_q[0][2] <= r02;
      rot_q[1][0] <= r10;
      rot_q[1][1] <= r11;
      rot_q[1][2] <= r12;
      rot_q[2][0] <= r20;
      rot_q[2][1] <= r21;
      rot_q[2][2] <= r22;
      t_q[0]      <= tx;
      t_q[1]      <= ty;
      t_q[2]      <= tz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= S_MUL0;
      out_valid <= 1'b0;
      out_row   <= 2'd0;
      out_ok    <= 1'b0;
      gate_mode <= GATE_FINE;
      for (int i = 0; i < ROWS; i++) begin
        for (int j = 0; j < COLS; j++) begin
          pose[i][j] <= (i == j) ? ONE : '0;
        end
      end
    end else begin
      if (cfg_wr_en) begin
        gate_mode <= cfg_wr_data;
      end

      // If the gate passes, merge the lanes into the pose; either way start the three result rows.
      if (finish) begin
        if (gate_ok) begin
          pose <= lane_res;
        end
        out_valid <= 1'b1;
        out_row   <= 2'd0;
        out_ok    <= gate_ok;
      end else if (out_valid && !out_stall) begin
        if (out_row == ROW_LAST) begin
          out_valid <= 1'b0;
        end else begin
          out_row <= out_row + 2'd1;
        end
      end

      if (in_acc) begin
        busy <= 1'b1;
        step <= S_MUL0;
      end else if (busy) begin
        unique case (step)
          S_MUL0: step <= S_MUL1;
          S_MUL1: step <= S_MUL2;
          S_MUL2: step <= S_DONE;
          S_DONE: if (finish) busy <= 1'b0;
        endcase
      end
    end
  end

  assign row_index = out_row;
  assign col0      = pose[out_row][0];
  assign col1      = pose[out_row][1];
  assign col2      = pose[out_row][2];
  assign col3      = pose[out_row][3];
  assign accepted  = out_ok;
  assign last_row  = (out_row == ROW_LAST);

endmodule

`default_nettype wire

FILE: sv/gpa_gate.sv
`default_nettype none

module gpa_gate import gpa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] tx,
  input  logic signed [DATA_W-1:0] ty,
  input  logic signed [DATA_W-1:0] tz,
  output logic                     ok
);

  localparam int SQ_W = 2 * DATA_W;
  localparam logic [SQ_W-1:0] ONE2       = SQ_W'(1) << (2 * FRAC_BITS);
  localparam logic [SQ_W-1:0] LOW_FINE   = ONE2 / SQ_W'(100);
  localparam logic [SQ_W-1:0] LOW_COARSE = (ONE2 / SQ_W'(4)) * SQ_W'(9);
  localparam logic [SQ_W-1:0] UPPER      = ONE2 * SQ_W'(2500);

  logic [SQ_W-1:0] sq_x, sq_y, sq_z, sq_sum;

  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] neg;
    neg = unsigned'(-v);
    return v[DATA_W-1] ? neg : unsigned'(v);
  endfunction

  assign sq_sum = sq_x + sq_y + sq_z;

  // Squares from the held translation; range check in the next cycle.
  always_ff @(posedge clk) begin
    sq_x <= SQ_W'(mag(tx)) * SQ_W'(mag(tx));
    sq_y <= SQ_W'(mag(ty)) * SQ_W'(mag(ty));
    sq_z <= SQ_W'(mag(tz)) * SQ_W'(mag(tz));
    unique case (mode)
      GATE_FINE:   ok <= (sq_sum > LOW_FINE) && (sq_sum < UPPER);
      GATE_COARSE: ok <= (sq_sum > LOW_COARSE) && (sq_sum < UPPER);
      default:     ok <= 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/gpa_lane.sv
`default_nettype none

module gpa_lane import gpa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  gpa_lane_ctrl_t           ctrl,
  input  logic signed [DATA_W-1:0] op_a,
  input  logic signed [DATA_W-1:0] op_b,
  input  logic signed [DATA_W-1:0] offset,
  output logic signed [DATA_W-1:0] result
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    sum;
  logic signed [ACC_W-1:0]    scaled;
  logic [ACC_W-DATA_W:0]      hi;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
    // Seed with the offset and the rounding half, then add the remaining terms.
    if (ctrl.acc_load) begin
      acc <= (ACC_W'(offset) <<< FRAC_BITS) + HALF + ACC_W'(prod);
    end else if (ctrl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign sum    = acc + ACC_W'(prod);
  assign scaled = sum >>> FRAC_BITS;
  assign hi     = scaled[ACC_W-1:DATA_W-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      result = scaled[DATA_W-1:0];
    end else if (scaled[ACC_W-1]) begin
      result = SAT_MIN;
    end else begin
      result = SAT_MAX;
    end
  end

endmodule

`default_nettype wire

FILE: sv/gpa_checker.sv
`default_nettype none
`include "gated_pose_accumulator_core_defines.svh"

module gpa_checker import gpa_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               row_index,
  input logic signed [DATA_W-1:0] col0,
  input logic                     accepted,
  input logic                     last_row
);

  `GPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(row_index) && $stable(col0) && $stable(accepted), "stalled result changed")

  `GPA_ASSERT_IMPL(a_last_flag, out_valid, last_row == (row_index == ROW_LAST), "last_row does not match row_index")

  `GPA_ASSERT_NEXT(a_row_step, out_valid && !out_stall && !last_row, out_valid && (row_index == $past(row_index) + 2'd1) && (accepted == $past(accepted)), "result rows out of order")

  `GPA_ASSERT_NEXT(a_group_start, out_valid && !out_stall && last_row, !out_valid || (row_index == 2'd0), "new result group does not start at row 0")

  `GPA_ASSERT_IMPL(a_reset_idle, $past(rst), !out_valid && !in_stall, "block not idle after reset")

endmodule

bind gated_pose_accumulator_core gpa_checker u_gpa_checker (.*);

`default_nettype wire
